// File: sv/assert_macros.svh
// assertion macros shared by the line rasterizer modules
// expects signals named clock and reset in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define CLR_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CLR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/clr_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the clipped line rasterizer
// no dependencies
package clr_pkg;

   typedef logic signed [7:0] coord_type;

   // canvas size is limited to this many rows and columns
   localparam logic [5:0] MAX_DIM = 6'd63;
   // visible writes allowed per line, the end marker excluded
   localparam logic [5:0] MAX_VISIBLE = 6'd63;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_CANVAS_WIDTH  = 1'b0,
      CSR_CANVAS_HEIGHT = 1'b1
   } csr_index_type;

   // classified line command as it sits in the queue
   typedef struct packed {
      coord_type   x0;
      coord_type   y0;
      coord_type   x1;
      coord_type   y1;
      logic [7:0]  dx;        // |x1 - x0|
      logic [7:0]  dy_mag;    // |y1 - y0|
      logic        x_dec;     // step x downward
      logic        y_dec;     // step y downward
      logic [7:0]  glyph;
      logic [23:0] fore;
      logic [23:0] back;
   } clr_cmd_type;

   // queue status seen by front and back
   typedef struct packed {
      logic full;
      logic not_empty;
   } clr_qstat_type;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_WALK = 1'b1
   } clr_state_type;

endpackage

// File: sv/clipped_line_rasterizer.sv
`timescale 1ns / 1ps
// Clipped line rasterizer. A line command (two signed 8-bit endpoints, a glyph
// and two packed colors) is taken on the req_ channel into a two-entry queue;
// the walker then traces the all-octant integer Bresenham line from start to
// end and returns one item on the rsp_ channel for each visited cell inside
// the canvas (columns 0 to canvas_width-1, rows 0 to canvas_height-1). The
// final visited point always yields an item with last_of_line set; if that
// point lies off the canvas, a marker with visible low and cell 0,0 is sent
// instead. The walker loads a line from the queue while idle and then does one
// Bresenham step per clock; rsp_stall holds the walk where it is while an item
// is pending. Up to two further commands are taken while a line is being
// walked. canvas_width and canvas_height are written through csr_ (index 0
// and 1), both reset to 32, and should only be changed while no line is in
// flight.
// depends on clr_pkg, clr_front, clr_queue, clr_walker
module clipped_line_rasterizer import clr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // command channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_start_x,
   input  logic [7:0]  req_start_y,
   input  logic [7:0]  req_end_x,
   input  logic [7:0]  req_end_y,
   input  logic [7:0]  req_glyph,
   input  logic [23:0] req_fore_color,
   input  logic [23:0] req_back_color,
   // pixel write channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_cell_x,
   output logic [5:0]  rsp_cell_y,
   output logic        rsp_visible,
   output logic [7:0]  rsp_cell_glyph,
   output logic [23:0] rsp_cell_fore,
   output logic [23:0] rsp_cell_back,
   output logic        rsp_last_of_line,
   // configuration writes
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [5:0]  csr_write_data
);

   // canvas size registers
   logic [5:0]    canvas_width_ff, canvas_width_in;
   logic [5:0]    canvas_height_ff, canvas_height_in;

   // front to queue to walker
   clr_qstat_type q_stat;
   clr_cmd_type   front_cmd;
   clr_cmd_type   q_data;
   logic          push;
   logic          pop;

   always_comb begin
      canvas_width_in  = canvas_width_ff;
      canvas_height_in = canvas_height_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_CANVAS_WIDTH:  canvas_width_in  = csr_write_data;
            CSR_CANVAS_HEIGHT: canvas_height_in = csr_write_data;
            default: begin
               canvas_width_in  = canvas_width_ff;
               canvas_height_in = canvas_height_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_width_ff  <= 6'd32;
         canvas_height_ff <= 6'd32;
      end else begin
         canvas_width_ff  <= canvas_width_in;
         canvas_height_ff <= canvas_height_in;
      end
   end

   // accept and classify: deltas and step directions worked out on entry
   clr_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .start_x    (coord_type'(req_start_x)),
      .start_y    (coord_type'(req_start_y)),
      .end_x      (coord_type'(req_end_x)),
      .end_y      (coord_type'(req_end_y)),
      .glyph      (req_glyph),
      .fore_color (req_fore_color),
      .back_color (req_back_color),
      .q_stat     (q_stat),
      .push       (push),
      .cmd        (front_cmd)
   );

   // two commands of slack so the front keeps taking items during a walk
   clr_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (front_cmd),
      .pop     (pop),
      .rd_data (q_data),
      .q_stat  (q_stat)
   );

   // stepping engine with the registered output stage
   clr_walker u_walker (
      .clock         (clock),
      .reset         (reset),
      .canvas_width  (canvas_width_ff),
      .canvas_height (canvas_height_ff),
      .q_stat        (q_stat),
      .q_data        (q_data),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .cell_x        (rsp_cell_x),
      .cell_y        (rsp_cell_y),
      .visible       (rsp_visible),
      .cell_glyph    (rsp_cell_glyph),
      .cell_fore     (rsp_cell_fore),
      .cell_back     (rsp_cell_back),
      .last_of_line  (rsp_last_of_line)
   );

endmodule

// File: sv/clr_front.sv
`timescale 1ns / 1ps
// front end: accepts line commands and classifies them (deltas, directions)
// depends on clr_pkg
module clr_front import clr_pkg::*; (
   input  logic          req_valid,
   output logic          req_stall,
   input  coord_type     start_x,
   input  coord_type     start_y,
   input  coord_type     end_x,
   input  coord_type     end_y,
   input  logic [7:0]    glyph,
   input  logic [23:0]   fore_color,
   input  logic [23:0]   back_color,
   input  clr_qstat_type q_stat,
   output logic          push,
   output clr_cmd_type   cmd
);

   logic signed [8:0] diff_x;
   logic signed [8:0] diff_y;
   logic [8:0]        abs_x;
   logic [8:0]        abs_y;

   assign req_stall = q_stat.full;
   assign push      = req_valid && !q_stat.full;

   always_comb begin
      diff_x = {end_x[7], end_x} - {start_x[7], start_x};
      diff_y = {end_y[7], end_y} - {start_y[7], start_y};
      abs_x  = diff_x[8] ? 9'(-diff_x) : 9'(diff_x);
      abs_y  = diff_y[8] ? 9'(-diff_y) : 9'(diff_y);

      cmd.x0     = start_x;
      cmd.y0     = start_y;
      cmd.x1     = end_x;
      cmd.y1     = end_y;
      cmd.dx     = abs_x[7:0];
      cmd.dy_mag = abs_y[7:0];
      cmd.x_dec  = !(start_x < end_x);
      cmd.y_dec  = !(start_y < end_y);
      cmd.glyph  = glyph;
      cmd.fore   = fore_color;
      cmd.back   = back_color;
   end

endmodule

// File: sv/clr_queue.sv
`timescale 1ns / 1ps
// two-entry command queue between the front end and the line walker
// depends on clr_pkg and assert_macros.svh
`include "assert_macros.svh"
module clr_queue import clr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  clr_cmd_type   wr_data,
   input  logic          pop,
   output clr_cmd_type   rd_data,
   output clr_qstat_type q_stat
);

   clr_cmd_type mem [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   always_comb begin
      q_stat.full      = (count_ff == 2'd2);
      q_stat.not_empty = (count_ff != 2'd0);
      rd_data          = mem[rd_ptr_ff];
      wr_ptr_in        = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in        = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in         = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

   `CLR_ASSERT_IMP(a_ptrs_meet, (count_ff == 2'd0 || count_ff == 2'd2), (wr_ptr_ff == rd_ptr_ff), "queue pointers disagree with empty or full count")
   `CLR_ASSERT_IMP(a_ptrs_apart, (count_ff == 2'd1), (wr_ptr_ff != rd_ptr_ff), "queue pointers disagree with single entry count")

endmodule

// File: sv/clr_walker.sv
`timescale 1ns / 1ps
// back end: walks a line a step per unstalled cycle, registers pixel writes
// depends on clr_pkg and assert_macros.svh
`include "assert_macros.svh"
module clr_walker import clr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic [5:0]    canvas_width,
   input  logic [5:0]    canvas_height,
   input  clr_qstat_type q_stat,
   input  clr_cmd_type   q_data,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [5:0]    cell_x,
   output logic [5:0]    cell_y,
   output logic          visible,
   output logic [7:0]    cell_glyph,
   output logic [23:0]   cell_fore,
   output logic [23:0]   cell_back,
   output logic          last_of_line
);

   clr_state_type      state_ff, state_in;
   clr_cmd_type        cmd_ff;
   coord_type          cx_ff, cx_in;
   coord_type          cy_ff, cy_in;
   logic signed [10:0] err_ff, err_in, err_init;
   logic [5:0]         count_ff, count_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [5:0]         rsp_x_ff, rsp_y_ff;
   logic               rsp_vis_ff, rsp_last_ff;
   logic [7:0]         rsp_glyph_ff;
   logic [23:0]        rsp_fore_ff, rsp_back_ff;

   logic               advance;
   logic [5:0]         w_eff, h_eff;
   logic signed [11:0] e2, dx12, neg_dy12;
   logic               step_x, step_y, at_end, term, vis, emit_vis, emit;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_stat.not_empty) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (advance && term) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      pop     = 1'b0;
      advance = 1'b0;
      case (state_ff)
         ST_IDLE: pop = q_stat.not_empty;
         ST_WALK: advance = !rsp_valid_ff || !rsp_stall;
         default: begin
            pop     = 1'b0;
            advance = 1'b0;
         end
      endcase
   end

   // one bresenham step with its early exits
   always_comb begin
      w_eff    = (canvas_width > MAX_DIM) ? MAX_DIM : canvas_width;
      h_eff    = (canvas_height > MAX_DIM) ? MAX_DIM : canvas_height;
      err_init = $signed({3'b000, q_data.dx}) - $signed({3'b000, q_data.dy_mag});

      e2       = {err_ff, 1'b0};
      dx12     = $signed({4'b0000, cmd_ff.dx});
      neg_dy12 = -$signed({4'b0000, cmd_ff.dy_mag});
      step_x   = (e2 >= neg_dy12);
      step_y   = (e2 <= dx12);
      at_end   = (cx_ff == cmd_ff.x1) && (cy_ff == cmd_ff.y1);
      term     = at_end || (step_x && cx_ff == cmd_ff.x1) || (step_y && cy_ff == cmd_ff.y1);

      vis      = !cx_ff[7] && !cy_ff[7] &&
                 (cx_ff[6:0] < {1'b0, w_eff}) &&
                 (cy_ff[6:0] < {1'b0, h_eff});
      emit_vis = vis && (count_ff != MAX_VISIBLE);
      emit     = advance && (emit_vis || term);

      cx_in    = cx_ff;
      cy_in    = cy_ff;
      err_in   = err_ff;
      count_in = count_ff;
      if (pop) begin
         cx_in    = q_data.x0;
         cy_in    = q_data.y0;
         err_in   = err_init;
         count_in = 6'd0;
      end else if (advance) begin
         if (step_x) begin
            cx_in  = cx_ff + (cmd_ff.x_dec ? 8'hFF : 8'h01);
            err_in = err_in - $signed({3'b000, cmd_ff.dy_mag});
         end
         if (step_y) begin
            cy_in  = cy_ff + (cmd_ff.y_dec ? 8'hFF : 8'h01);
            err_in = err_in + $signed({3'b000, cmd_ff.dx});
         end
         if (emit_vis) count_in = count_ff + 6'd1;
      end

      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cx_ff        <= '0;
         cy_ff        <= '0;
         err_ff       <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
         err_ff       <= err_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff <= q_data;
      end
      if (emit) begin
         rsp_x_ff     <= emit_vis ? cx_ff[5:0] : 6'd0;
         rsp_y_ff     <= emit_vis ? cy_ff[5:0] : 6'd0;
         rsp_vis_ff   <= emit_vis;
         rsp_last_ff  <= term;
         rsp_glyph_ff <= cmd_ff.glyph;
         rsp_fore_ff  <= cmd_ff.fore;
         rsp_back_ff  <= cmd_ff.back;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign cell_x       = rsp_x_ff;
   assign cell_y       = rsp_y_ff;
   assign visible      = rsp_vis_ff;
   assign cell_glyph   = rsp_glyph_ff;
   assign cell_fore    = rsp_fore_ff;
   assign cell_back    = rsp_back_ff;
   assign last_of_line = rsp_last_ff;

   `CLR_ASSERT_IMP(a_marker_form, (rsp_valid_ff && !rsp_vis_ff), (rsp_last_ff && rsp_x_ff == 6'd0 && rsp_y_ff == 6'd0), "clipped marker must be last and at the origin")
   `CLR_ASSERT_IMP(a_idle_last, (state_ff == ST_IDLE && rsp_valid_ff), rsp_last_ff, "pending item while idle is not the end of a line")
   `CLR_ASSERT_NEXT(a_end_emits, (state_ff == ST_WALK && advance && term), (rsp_valid_ff && rsp_last_ff), "line ended without a final item")

endmodule

// File: test/clipped_line_rasterizer_checker.sv
`timescale 1ns / 1ps
// checker for the clipped line rasterizer: watches the req_, rsp_ and csr_ ports,
// predicts the pixel writes of each line and compares them in order
// depends on clr_pkg
module clipped_line_rasterizer_checker import clr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_start_x,
   input  logic [7:0]  req_start_y,
   input  logic [7:0]  req_end_x,
   input  logic [7:0]  req_end_y,
   input  logic [7:0]  req_glyph,
   input  logic [23:0] req_fore_color,
   input  logic [23:0] req_back_color,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [5:0]  rsp_cell_x,
   input  logic [5:0]  rsp_cell_y,
   input  logic        rsp_visible,
   input  logic [7:0]  rsp_cell_glyph,
   input  logic [23:0] rsp_cell_fore,
   input  logic [23:0] rsp_cell_back,
   input  logic        rsp_last_of_line,
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [5:0]  csr_write_data,
   output int          error_count,
   output int          pending_count,
   output int          pixel_count
);

   localparam int WALK_GUARD = 600;

   typedef struct packed {
      logic [5:0]  x;
      logic [5:0]  y;
      logic        visible;
      logic [7:0]  glyph;
      logic [23:0] fore;
      logic [23:0] back;
      logic        last;
   } pixel_write_type;

   pixel_write_type expected_pixels[$];
   pixel_write_type seen;
   pixel_write_type want;
   int canvas_w = 32;
   int canvas_h = 32;

   initial begin
      error_count = 0;
      pending_count = 0;
      pixel_count = 0;
   end

   // bresenham walk with early exits, clipped to the canvas
   function automatic void predict_line(input coord_type x0c, input coord_type y0c,
                                        input coord_type x1c, input coord_type y1c,
                                        input logic [7:0] glyph,
                                        input logic [23:0] fore, input logic [23:0] back);
      int x0, y0, x1, y1, w, h, dx, dy, step_x, step_y, err, e2, cx, cy, writes, guard;
      bit in_view;
      pixel_write_type px;
      x0 = x0c;
      y0 = y0c;
      x1 = x1c;
      y1 = y1c;
      w = (canvas_w > int'(MAX_DIM)) ? int'(MAX_DIM) : canvas_w;
      h = (canvas_h > int'(MAX_DIM)) ? int'(MAX_DIM) : canvas_h;
      dx = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy = (y1 > y0) ? y0 - y1 : y1 - y0;
      step_x = (x0 < x1) ? 1 : -1;
      step_y = (y0 < y1) ? 1 : -1;
      err = dx + dy;
      cx = x0;
      cy = y0;
      writes = 0;
      in_view = 0;
      px.glyph = glyph;
      px.fore = fore;
      px.back = back;
      px.last = 1'b0;
      px.visible = 1'b1;
      for (guard = 0; guard < WALK_GUARD; guard++) begin
         in_view = cx >= 0 && cy >= 0 && cx < w && cy < h;
         if (in_view && writes < int'(MAX_VISIBLE)) begin
            px.x = cx[5:0];
            px.y = cy[5:0];
            expected_pixels.push_back(px);
            writes++;
         end else if (in_view) begin
            in_view = 0;
         end
         if (cx == x1 && cy == y1) break;
         e2 = 2 * err;
         if (e2 >= dy) begin
            if (cx == x1) break;
            err += dy;
            cx += step_x;
         end
         if (e2 <= dx) begin
            if (cy == y1) break;
            err += dx;
            cy += step_y;
         end
      end
      if (in_view && writes > 0) begin
         // final point was drawn: tag its own write
         px = expected_pixels.pop_back();
         px.last = 1'b1;
         expected_pixels.push_back(px);
      end else begin
         // final point off the canvas: end marker at 0,0
         px.x = 6'd0;
         px.y = 6'd0;
         px.visible = 1'b0;
         px.last = 1'b1;
         expected_pixels.push_back(px);
      end
   endfunction

   task automatic compare_field(input string field, input logic [23:0] exp_val,
                                input logic [23:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_val,
                  act_val);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         canvas_w = 32;
         canvas_h = 32;
         expected_pixels.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_CANVAS_WIDTH) canvas_w = csr_write_data;
            else canvas_h = csr_write_data;
         end
         // check before predicting so a stray write cannot match a fresh line
         if (rsp_valid && !rsp_stall) begin
            seen.x = rsp_cell_x;
            seen.y = rsp_cell_y;
            seen.visible = rsp_visible;
            seen.glyph = rsp_cell_glyph;
            seen.fore = rsp_cell_fore;
            seen.back = rsp_cell_back;
            seen.last = rsp_last_of_line;
            pixel_count++;
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected pixel write, expected none, actual %h", $time,
                        seen);
               error_count++;
            end else begin
               want = expected_pixels.pop_front();
               compare_field("cell_x", 24'(want.x), 24'(seen.x));
               compare_field("cell_y", 24'(want.y), 24'(seen.y));
               compare_field("visible", 24'(want.visible), 24'(seen.visible));
               compare_field("cell_glyph", 24'(want.glyph), 24'(seen.glyph));
               compare_field("cell_fore", want.fore, seen.fore);
               compare_field("cell_back", want.back, seen.back);
               compare_field("last_of_line", 24'(want.last), 24'(seen.last));
            end
         end
         if (req_valid && !req_stall)
            predict_line(req_start_x, req_start_y, req_end_x, req_end_y, req_glyph,
                         req_fore_color, req_back_color);
      end
      pending_count <= expected_pixels.size();
   end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// top of the clipped line rasterizer test: clock, reset, line commands, canvas
// writes, random stalls and the verdict; depends on clr_pkg, the block and its checker
module testbench;
   import clr_pkg::*;

   // the longest line walk without stalls fits well within this margin
   localparam int WALK_CYCLES = 300;
   // cycles with no item moving before the run is declared hung
   localparam int IDLE_LIMIT = 4000;
   localparam int PHASES = 8;
   localparam int RANDOM_LINES = 25;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_start_x = 8'd0;
   logic [7:0]  req_start_y = 8'd0;
   logic [7:0]  req_end_x = 8'd0;
   logic [7:0]  req_end_y = 8'd0;
   logic [7:0]  req_glyph = 8'd0;
   logic [23:0] req_fore_color = 24'd0;
   logic [23:0] req_back_color = 24'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [5:0]  rsp_cell_x;
   logic [5:0]  rsp_cell_y;
   logic        rsp_visible;
   logic [7:0]  rsp_cell_glyph;
   logic [23:0] rsp_cell_fore;
   logic [23:0] rsp_cell_back;
   logic        rsp_last_of_line;
   logic        csr_write_enable = 1'b0;
   logic [0:0]  csr_index = CSR_CANVAS_WIDTH;
   logic [5:0]  csr_write_data = 6'd0;

   int error_count;
   int pending_count;
   int pixel_count;
   int line_count = 0;
   int idle_cycles = 0;
   int stall_left = 0;
   int stall_draw;
   // when set, neither side inserts gaps or stalls
   bit calm = 1'b0;

   // canvas size per phase; phase 0 runs on the reset values
   int phase_w [0:PHASES-1] = '{32, 63, 0, 1, 63, 9, 0, 45};
   int phase_h [0:PHASES-1] = '{32, 63, 0, 1, 1, 50, 20, 63};

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   clipped_line_rasterizer DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_start_x(req_start_x),
      .req_start_y(req_start_y),
      .req_end_x(req_end_x),
      .req_end_y(req_end_y),
      .req_glyph(req_glyph),
      .req_fore_color(req_fore_color),
      .req_back_color(req_back_color),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_cell_x(rsp_cell_x),
      .rsp_cell_y(rsp_cell_y),
      .rsp_visible(rsp_visible),
      .rsp_cell_glyph(rsp_cell_glyph),
      .rsp_cell_fore(rsp_cell_fore),
      .rsp_cell_back(rsp_cell_back),
      .rsp_last_of_line(rsp_last_of_line),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   clipped_line_rasterizer_checker pixel_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_start_x(req_start_x),
      .req_start_y(req_start_y),
      .req_end_x(req_end_x),
      .req_end_y(req_end_y),
      .req_glyph(req_glyph),
      .req_fore_color(req_fore_color),
      .req_back_color(req_back_color),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_cell_x(rsp_cell_x),
      .rsp_cell_y(rsp_cell_y),
      .rsp_visible(rsp_visible),
      .rsp_cell_glyph(rsp_cell_glyph),
      .rsp_cell_fore(rsp_cell_fore),
      .rsp_cell_back(rsp_cell_back),
      .rsp_last_of_line(rsp_last_of_line),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .error_count(error_count),
      .pending_count(pending_count),
      .pixel_count(pixel_count)
   );

   // pixel side back-pressure: a random stall, possibly none, after each item taken,
   // plus an occasional stall while nothing is offered
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         stall_draw = calm ? 0 : $urandom_range(0, 9);
         stall_left <= stall_draw;
         rsp_stall <= (stall_draw != 0);
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else if (stall_left == 1) begin
         stall_left <= 0;
         rsp_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
         stall_left <= $urandom_range(1, 9);
         rsp_stall <= 1'b1;
      end
   end

   // watchdog: any item moving on either channel counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("clipped_line_rasterizer test failed");
            $finish;
         end
      end
   end

   // offer one line command after a random gap and hold it until taken;
   // valid stays high when the next command follows with no gap
   task automatic send_line(input logic [7:0] x0, input logic [7:0] y0,
                            input logic [7:0] x1, input logic [7:0] y1,
                            input logic [7:0] glyph,
                            input logic [23:0] fore, input logic [23:0] back);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_start_x <= x0;
      req_start_y <= y0;
      req_end_x <= x1;
      req_end_y <= y1;
      req_glyph <= glyph;
      req_fore_color <= fore;
      req_back_color <= back;
      do @(posedge clock); while (req_stall);
      line_count++;
   endtask

   // stop offering and wait until every expected pixel write has come back
   task automatic drain_lines();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // both registers, width first and then height
   task automatic write_canvas(input int w, input int h);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_CANVAS_WIDTH;
      csr_write_data <= w[5:0];
      @(posedge clock);
      csr_index <= CSR_CANVAS_HEIGHT;
      csr_write_data <= h[5:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // mostly near the canvas so lines cross its edges; sometimes anywhere
   function automatic logic [7:0] pick_coord(input int span);
      int v;
      if ($urandom_range(0, 9) < 7) v = int'($urandom_range(0, span + 16)) - 8;
      else v = $urandom_range(0, 255);
      return v[7:0];
   endfunction

   initial begin
      int span;
      logic [7:0] x0, y0, x1, y1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            drain_lines();
            write_canvas(phase_w[p], phase_h[p]);
         end
         if (p == 0) begin
            // single point on and off the canvas, with extreme glyph and colors
            send_line(8'd5, 8'd5, 8'd5, 8'd5, 8'h00, 24'h000000, 24'hFFFFFF);
            send_line(8'hFD, 8'd40, 8'hFD, 8'd40, 8'hFF, 24'hFFFFFF, 24'h000000);
            // corner to corner and edge to edge over the whole coordinate range
            send_line(8'h80, 8'h80, 8'd127, 8'd127, 8'hAA, 24'hAAAAAA, 24'h555555);
            send_line(8'd127, 8'h80, 8'h80, 8'd127, 8'h55, 24'h555555, 24'hAAAAAA);
            send_line(8'd127, 8'd127, 8'h80, 8'h80, 8'h80, 24'h800000, 24'h000080);
            send_line(8'h80, 8'd0, 8'd127, 8'd0, 8'h7F, 24'h7FFFFF, 24'hFFFF7F);
            // lines ending on a drawn cell, all directions
            send_line(8'd0, 8'd0, 8'd31, 8'd31, 8'h2A, 24'h123456, 24'h654321);
            send_line(8'd0, 8'd31, 8'd31, 8'd0, 8'h2B, 24'hFF0000, 24'h00FF00);
            send_line(8'd0, 8'd10, 8'd31, 8'd10, 8'h2D, 24'h0000FF, 24'hFFFF00);
            send_line(8'd31, 8'd10, 8'd0, 8'd10, 8'h3D, 24'h00FFFF, 24'hFF00FF);
            send_line(8'd7, 8'hFB, 8'd7, 8'd31, 8'h7C, 24'h010101, 24'hFEFEFE);
            send_line(8'd2, 8'd0, 8'd9, 8'd31, 8'h2F, 24'h0F0F0F, 24'hF0F0F0);
            send_line(8'd31, 8'd10, 8'd0, 8'd3, 8'h5C, 24'h3C3C3C, 24'hC3C3C3);
            // lines whose final point is clipped
            send_line(8'd20, 8'd20, 8'hEC, 8'hEC, 8'h23, 24'h111111, 24'h222222);
            send_line(8'd40, 8'd5, 8'hFB, 8'd40, 8'h24, 24'h333333, 24'h444444);
            send_line(8'd31, 8'd31, 8'd32, 8'd32, 8'h25, 24'h666666, 24'h777777);
         end else if (p == 1) begin
            // largest canvas: a full-length diagonal and lines through it
            send_line(8'd0, 8'd0, 8'd62, 8'd62, 8'h41, 24'hABCDEF, 24'hFEDCBA);
            send_line(8'hF6, 8'hF6, 8'd70, 8'd70, 8'h42, 24'h0A0B0C, 24'hC0B0A0);
            send_line(8'd62, 8'd0, 8'd0, 8'd62, 8'h43, 24'h999999, 24'h888888);
            send_line(8'd0, 8'd62, 8'd62, 8'd62, 8'h44, 24'hDDDDDD, 24'hEEEEEE);
         end else if (p == 2) begin
            // empty canvas: only the end marker can come back
            send_line(8'd0, 8'd0, 8'd5, 8'd5, 8'h45, 24'hCCCCCC, 24'hBBBBBB);
         end
         span = (phase_w[p] > phase_h[p]) ? phase_w[p] : phase_h[p];
         for (int n = 0; n < RANDOM_LINES; n++) begin
            // stretches with no idling at all now and then
            if (n % 12 == 0) calm = (p == 4) || ($urandom_range(0, 3) == 0);
            x0 = pick_coord(span);
            y0 = pick_coord(span);
            if ($urandom_range(0, 4) == 0) begin
               // short line close to its start
               x1 = 8'(x0 + $urandom_range(0, 6) - 3);
               y1 = 8'(y0 + $urandom_range(0, 6) - 3);
            end else begin
               x1 = pick_coord(span);
               y1 = pick_coord(span);
            end
            send_line(x0, y0, x1, y1, 8'($urandom_range(0, 255)), 24'($urandom),
                      24'($urandom));
         end
      end
      drain_lines();
      // let a stray late write show up before the verdict
      repeat (WALK_CYCLES) @(posedge clock);
      $display("sent %0d line commands over %0d canvas sizes, empty and full canvas included;",
               line_count, PHASES);
      $display("checked %0d pixel writes and end markers", pixel_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("clipped_line_rasterizer test passed");
      end else begin
         $display("clipped_line_rasterizer test failed");
      end
      $finish;
   end

endmodule
